>>> hw/rtl/flsa_pkg.sv
// Shared types and constants of the free-list slot allocator.
// No dependencies; imported by flsa_front, flsa_back and the top level.
`default_nettype none

package flsa_pkg;

  // Pool geometry
  localparam int unsigned Slots     = 256;
  localparam int unsigned SlotBits  = $clog2(Slots);
  localparam int unsigned CountBits = $clog2(Slots + 1);
  localparam int unsigned TypeBits  = 8;

  // Port field widths
  localparam int unsigned ItemTypeW  = 8;
  localparam int unsigned SlotIndexW = 10;
  localparam int unsigned StatusW    = 3;

  // Command queue between front and back
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrBits = $clog2(QDepth);
  localparam int unsigned QCntBits = $clog2(QDepth + 1);

  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } flsa_cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StEmpty    = 3'd1,
    StNull     = 3'd2,
    StRange    = 3'd3,
    StNotOwned = 3'd4
  } flsa_status_e;

  // Class of a command as sorted by the front end
  typedef enum logic [1:0] {
    OpAlloc = 2'd0,
    OpFree  = 2'd1,
    OpNull  = 2'd2,
    OpRange = 2'd3
  } flsa_kind_e;

  typedef struct packed {
    flsa_kind_e          kind;
    logic [TypeBits-1:0] tag;
    logic [SlotBits-1:0] idx;
  } flsa_op_t;

endpackage

`default_nettype wire

>>> hw/rtl/flsa_front.sv
// Front end: takes command beats, sorts them by kind and range, and queues them.
// Depends on flsa_pkg.
`default_nettype none

module flsa_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [flsa_pkg::ItemTypeW-1:0]     item_type_i,
  input  logic [flsa_pkg::SlotIndexW-1:0]    slot_index_i,
  output logic                               op_valid_o,
  input  logic                               op_ready_i,
  output flsa_pkg::flsa_op_t                 op_o
);
  import flsa_pkg::*;

  flsa_op_t             entry_q [QDepth];
  logic [QPtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntBits-1:0]  count_q;
  flsa_op_t             op_new;
  logic                 push, pop;

  always_comb begin
    op_new.tag = item_type_i[TypeBits-1:0];
    op_new.idx = slot_index_i[SlotBits-1:0];
    if (cmd_i == CmdFree) begin
      op_new.kind = (slot_index_i >= SlotIndexW'(Slots)) ? OpRange : OpFree;
    end else begin
      op_new.kind = (op_new.tag == '0) ? OpNull : OpAlloc;
    end
  end

  assign in_ready_o = (count_q != QCntBits'(QDepth));
  assign op_valid_o = (count_q != '0);
  assign op_o       = entry_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = op_valid_o & op_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPtrBits'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPtrBits'(1);
      if (push && !pop) begin
        count_q <= count_q + QCntBits'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= op_new;
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntBits'(QDepth)) else $error("queue count overflow");
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == QCntBits'(QDepth)) && !pop |=> count_q == QCntBits'(QDepth))
    else $error("queue lost an entry while full");
  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !pop) else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/flsa_back.sv
// Back end: free stack memory, owned marks, type tags and the result register.
// Executes one queued command at a time. Depends on flsa_pkg.
`default_nettype none

module flsa_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            op_valid_i,
  output logic                            op_ready_o,
  input  flsa_pkg::flsa_op_t              op_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [flsa_pkg::StatusW-1:0]    status_o,
  output logic [flsa_pkg::SlotBits-1:0]   granted_slot_o,
  output logic [flsa_pkg::CountBits-1:0]  free_count_o
);
  import flsa_pkg::*;

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SExec = 3'b010,
    SPop  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  flsa_op_t             op_q;
  logic                 own_rd_q;
  logic [CountBits-1:0] top_q, top_d;
  logic [Slots-1:0]     owned_q;
  logic [Slots-1:0]     stack_vld_q;
  logic [SlotBits-1:0]  stack_mem [Slots];
  logic [TypeBits-1:0]  type_mem [Slots];

  logic                 rd_en, rd_vld_q;
  logic [SlotBits-1:0]  rd_addr, rd_addr_q, rd_data_q;
  logic                 wr_en;
  logic [SlotBits-1:0]  wr_addr;
  logic                 own_set, own_clr;
  logic [SlotBits-1:0]  own_idx, pop_slot;

  logic                 out_free, out_load;
  flsa_status_e         res_status;
  logic [SlotBits-1:0]  res_slot;
  logic                 out_valid_q;
  flsa_status_e         status_q;
  logic [SlotBits-1:0]  granted_q;
  logic [CountBits-1:0] count_q;

  assign out_free = !out_valid_q || out_ready_i;

  // An entry never written reads as Slots-1-k, taken from rd_addr_q while rd_vld_q is clear
  assign pop_slot = rd_vld_q ? rd_data_q : (SlotBits'(Slots - 1) - rd_addr_q);

  always_comb begin
    state_d    = state_q;
    top_d      = top_q;
    op_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = SlotBits'(top_q - CountBits'(1));
    wr_en      = 1'b0;
    wr_addr    = top_q[SlotBits-1:0];
    own_set    = 1'b0;
    own_clr    = 1'b0;
    own_idx    = op_q.idx;
    out_load   = 1'b0;
    res_status = StOk;
    res_slot   = '0;
    unique case (state_q)
      SIdle: begin
        op_ready_o = 1'b1;
        if (op_valid_i) state_d = SExec;
      end
      SExec: begin
        unique case (op_q.kind)
          OpNull: begin
            if (out_free) begin
              out_load   = 1'b1;
              res_status = StNull;
              state_d    = SIdle;
            end
          end
          OpRange: begin
            if (out_free) begin
              out_load   = 1'b1;
              res_status = StRange;
              state_d    = SIdle;
            end
          end
          OpAlloc: begin
            if (top_q == '0) begin
              if (out_free) begin
                out_load   = 1'b1;
                res_status = StEmpty;
                state_d    = SIdle;
              end
            end else begin
              rd_en   = 1'b1;
              state_d = SPop;
            end
          end
          OpFree: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = SIdle;
              if (!own_rd_q) begin
                res_status = StNotOwned;
              end else begin
                own_clr = 1'b1;
                if (top_q < CountBits'(Slots)) begin
                  wr_en = 1'b1;
                  top_d = top_q + CountBits'(1);
                end
              end
            end
          end
        endcase
      end
      SPop: begin
        // read data of the top entry is held in rd_data_q
        if (out_free) begin
          out_load = 1'b1;
          res_slot = pop_slot;
          own_idx  = pop_slot;
          own_set  = 1'b1;
          top_d    = top_q - CountBits'(1);
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      top_q       <= CountBits'(Slots);
      owned_q     <= '0;
      stack_vld_q <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      if (own_set) owned_q[own_idx] <= 1'b1;
      if (own_clr) owned_q[own_idx] <= 1'b0;
      if (wr_en)   stack_vld_q[wr_addr] <= 1'b1;
      if (rd_en)   rd_vld_q <= stack_vld_q[rd_addr];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // owned mark is sampled with the op; marks only change outside SIdle
  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_ready_o) begin
      op_q     <= op_i;
      own_rd_q <= owned_q[op_i.idx];
    end
    if (wr_en) stack_mem[wr_addr] <= op_q.idx;
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (own_set || own_clr) type_mem[own_idx] <= own_set ? op_q.tag : '0;
    if (out_load) begin
      status_q  <= res_status;
      granted_q <= res_slot;
      count_q   <= top_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign free_count_o   = count_q;

`ifndef SYNTHESIS
  a_top_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= CountBits'(Slots)) else $error("free count above pool size");
  a_refused_no_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StOk) |-> granted_slot_o == '0)
    else $error("refused command carries a slot");
  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StEmpty) |-> free_count_o == '0)
    else $error("pool empty reported with free slots");
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPop) |-> top_q != '0) else $error("pop from empty stack");
  a_pop_not_owned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    own_set |-> !owned_q[own_idx]) else $error("popped slot already owned");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/free_list_slot_allocator.sv
// Top level of the free-list slot allocator: front end, command queue, back end.
// Depends on flsa_pkg, flsa_front and flsa_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per beat:
//   cmd_i 0 allocates a slot tagged with item_type_i, cmd_i 1 frees slot_index_i.
//   Output channel (out_valid_o/out_ready_i) returns one result beat per command,
//   in order: status_o, granted_slot_o and the free count after the command.
//   A command passes through the queue, the back end's op register and the
//   result register; a granted allocate also passes through state SPop for the
//   registered read of the free-stack memory. The back end executes one command
//   at a time and takes the next only once it is back in SIdle.
//   A two-entry queue sits between front and back, so the input keeps taking
//   beats while a result waits in the output register.
//   After reset all 256 slots are free and slot 0 is handed out first; no
//   clearing pass is needed. When the receiver stalls, the result register holds
//   its beat, the back end waits, and the input stalls once the queue is full.
`default_nettype none

module free_list_slot_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [flsa_pkg::ItemTypeW-1:0]     item_type_i,
  input  logic [flsa_pkg::SlotIndexW-1:0]    slot_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [flsa_pkg::StatusW-1:0]       status_o,
  output logic [flsa_pkg::SlotBits-1:0]      granted_slot_o,
  output logic [flsa_pkg::CountBits-1:0]     free_count_o
);
  import flsa_pkg::*;

  flsa_op_t op;
  logic     op_valid, op_ready;

  flsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .item_type_i  (item_type_i),
    .slot_index_i (slot_index_i),
    .op_valid_o   (op_valid),
    .op_ready_i   (op_ready),
    .op_o         (op)
  );

  flsa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_ready_o     (op_ready),
    .op_i           (op),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .free_count_o   (free_count_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_free_list_slot_allocator.sv
// Testbench for free_list_slot_allocator: directed and random alloc/free beats
// checked against an in-bench model of the free-slot stack and owned marks.
// Depends on flsa_pkg and the free_list_slot_allocator RTL.
module tb_free_list_slot_allocator;
  import flsa_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 20;
  localparam int unsigned NumStatus  = 5;

  typedef struct packed {
    flsa_status_e         status;
    logic [SlotBits-1:0]  slot;
    logic [CountBits-1:0] count;
  } slot_result_t;

  logic                  clk_i;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic                  cmd_i        = 1'b0;
  logic [ItemTypeW-1:0]  item_type_i  = '0;
  logic [SlotIndexW-1:0] slot_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [StatusW-1:0]    status_o;
  logic [SlotBits-1:0]   granted_slot_o;
  logic [CountBits-1:0]  free_count_o;

  // pool model, advanced at each accepted input beat
  logic [SlotBits-1:0] free_stack_m [Slots];
  int unsigned         free_top_m;
  bit                  owned_m [Slots];
  logic [TypeBits-1:0] slot_tag_m [Slots];

  slot_result_t pending_results [$];
  bit           calm = 1'b0;
  int unsigned  beats_sent    = 0;
  int unsigned  results_seen  = 0;
  int unsigned  errors        = 0;
  int unsigned  quiet_cycles  = 0;
  int unsigned  status_hits [NumStatus];

  free_list_slot_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .item_type_i    (item_type_i),
    .slot_index_i   (slot_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .free_count_o   (free_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void reset_pool_model();
    for (int unsigned k = 0; k < Slots; k++) begin
      free_stack_m[k] = SlotBits'(Slots - 1 - k);
      owned_m[k]      = 1'b0;
      slot_tag_m[k]   = '0;
    end
    free_top_m = Slots;
    foreach (status_hits[k]) status_hits[k] = 0;
  endfunction

  function automatic slot_result_t apply_slot_command(flsa_cmd_e cmd,
                                                      logic [ItemTypeW-1:0] tag_in,
                                                      logic [SlotIndexW-1:0] idx_in);
    slot_result_t        res;
    logic [TypeBits-1:0] tag;
    logic [SlotBits-1:0] s;
    tag        = tag_in[TypeBits-1:0];
    res.status = StOk;
    res.slot   = '0;
    if (cmd == CmdAlloc) begin
      // null tag is refused before the pool is looked at
      if (tag == '0) begin
        res.status = StNull;
      end else if (free_top_m == 0) begin
        res.status = StEmpty;
      end else begin
        free_top_m--;
        s             = free_stack_m[free_top_m];
        owned_m[s]    = 1'b1;
        slot_tag_m[s] = tag;
        res.slot      = s;
      end
    end else if (idx_in >= Slots) begin
      res.status = StRange;
    end else if (!owned_m[idx_in[SlotBits-1:0]]) begin
      res.status = StNotOwned;
    end else begin
      s             = idx_in[SlotBits-1:0];
      owned_m[s]    = 1'b0;
      slot_tag_m[s] = '0;
      if (free_top_m < Slots) begin
        free_stack_m[free_top_m] = s;
        free_top_m++;
      end
    end
    res.count = CountBits'(free_top_m);
    return res;
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // sender: random idle cycles unless calm is set, then hold the beat until it is taken
  task automatic send_command(flsa_cmd_e cmd, logic [ItemTypeW-1:0] tag,
                              logic [SlotIndexW-1:0] idx);
    slot_result_t res;
    if (!calm)
      while ($urandom_range(99) < 17) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    item_type_i  <= tag;
    slot_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    res             = apply_slot_command(cmd, tag, idx);
    pending_results = {pending_results, res};
    beats_sent++;
  endtask

  // the unused field of each command carries random bits
  task automatic alloc_slot(logic [ItemTypeW-1:0] tag);
    send_command(CmdAlloc, tag, SlotIndexW'($urandom_range(1023)));
  endtask

  task automatic free_slot(logic [SlotIndexW-1:0] idx);
    send_command(CmdFree, ItemTypeW'($urandom_range(255)), idx);
  endtask

  task automatic test_directed_cases();
    alloc_slot('0);
    free_slot(10'd0);
    free_slot(10'd255);
    free_slot(10'd256);
    free_slot(10'd1023);
    free_slot(10'd512);
    send_command(CmdAlloc, 8'hFF, 10'h3FF);
    send_command(CmdAlloc, 8'h01, 10'h000);
    alloc_slot(8'h80);
    send_command(CmdFree, 8'hFF, 10'd1);
    send_command(CmdFree, 8'h00, 10'd1);
    alloc_slot(8'h55);
    alloc_slot('0);
    free_slot(10'd0);
    free_slot(10'd2);
    free_slot(10'd1);
    alloc_slot(8'hAA);
    free_slot(10'd1);
  endtask

  // fill the pool with no idling, poke the empty pool, free in random order, then free one slot again
  task automatic test_pool_exhaust();
    logic [SlotBits-1:0] order [Slots];
    logic [SlotBits-1:0] t;
    int unsigned         j;
    calm = 1'b1;
    repeat (Slots) alloc_slot(ItemTypeW'($urandom_range(255, 1)));
    calm = 1'b0;
    alloc_slot(8'hFF);
    alloc_slot('0);
    alloc_slot(ItemTypeW'($urandom_range(255, 1)));
    free_slot(SlotIndexW'(Slots));
    for (int unsigned k = 0; k < Slots; k++) order[k] = SlotBits'(k);
    for (int unsigned k = Slots - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    foreach (order[k]) free_slot(SlotIndexW'(order[k]));
    free_slot(SlotIndexW'(order[0]));
  endtask

  // mostly legal traffic; alloc share swings every 100 beats so occupancy moves
  task automatic test_random_mix(int unsigned n);
    int unsigned r, start, k, split;
    int          found;
    for (int unsigned i = 0; i < n; i++) begin
      r     = $urandom_range(99);
      split = ((i / 100) % 2 == 0) ? 70 : 35;
      found = -1;
      if (r >= split) begin
        start = $urandom_range(Slots - 1);
        for (k = 0; k < Slots && found < 0; k++)
          if (owned_m[(start + k) % Slots]) found = (start + k) % Slots;
      end
      if (r < 5)
        alloc_slot('0);
      else if (r < 10)
        free_slot(SlotIndexW'($urandom_range(1023, Slots)));
      else if (r < 15)
        free_slot(SlotIndexW'($urandom_range(Slots - 1)));
      else if (r < split || found < 0)
        alloc_slot(ItemTypeW'($urandom_range(255, 1)));
      else
        free_slot(SlotIndexW'(found));
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 17);
  end

  always @(posedge clk_i) begin : check_result
    slot_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result beat with none expected, got status %0d slot %0d count %0d",
                   $time, status_o, granted_slot_o, free_count_o);
      end else begin
        want = pending_results.pop_front();
        status_hits[want.status]++;
        check_field("status", 16'(want.status), 16'(status_o));
        check_field("granted_slot", 16'(want.slot), 16'(granted_slot_o));
        check_field("free_count", 16'(want.count), 16'(free_count_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: timeout, no beat moved for %0d cycles", $time, StallLimit);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    reset_pool_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_pool_exhaust();
    test_random_mix(500);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("covered %0d command beats and %0d result beats, incl. full drain and refill",
             beats_sent, results_seen);
    $display("status hits ok/empty/null/range/not-owned: %0d/%0d/%0d/%0d/%0d",
             status_hits[StOk], status_hits[StEmpty], status_hits[StNull],
             status_hits[StRange], status_hits[StNotOwned]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/flsa_pkg.sv
hw/rtl/flsa_front.sv
hw/rtl/flsa_back.sv
hw/rtl/free_list_slot_allocator.sv
tb/tb_free_list_slot_allocator.sv
